>>> hdl/binomial_3x3_image_smoother_top_defines.svh
// assertion macros shared by the smoother rtl
`ifndef BINOMIAL_3X3_IMAGE_SMOOTHER_TOP_DEFINES_SVH
`define BINOMIAL_3X3_IMAGE_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BIS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BIS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> hdl/bis_pkg.sv
package bis_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 16;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int IDX_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int SUM_W        = PIXEL_BITS + 2;
    localparam int OUT_W        = 20;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = Q_PTR_W + 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        OP_FIRST,
        OP_BODY,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        logic                  kind;
        logic [PIXEL_BITS-1:0] pixel;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] smoothed;
        logic             end_of_row;
        logic             end_of_frame;
    } t_out_word;

    typedef struct packed {
        t_op_kind         kind;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] hs;
        logic             eor;
        logic             eof;
    } t_op;

    typedef struct packed {
        logic a_valid;
        t_op  a;
        logic b_valid;
        t_op  b;
    } t_push;

endpackage

>>> hdl/binomial_3x3_image_smoother_top.sv
// items pass a small queue, which absorbs the extra result of each row's last pixel,
// then stage one (line-store read) and the output register; throughput: one item per
// cycle unless the queue or output stalls; one line-store read-modify-write per cycle
// reset: control state clears, frame size returns to 640 x 480; the line store is
// not cleared and is written by the first row of every frame
module binomial_3x3_image_smoother_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bis_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bis_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bis_pkg::t_out_word            o_out_word
);
    import bis_pkg::*;

    t_push push;
    t_op   head;
    logic  space, head_valid, pop;

    bis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_space    (space),
        .o_in_ready (o_in_ready),
        .o_push     (push)
    );

    bis_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_space      (space),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    bis_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

endmodule

>>> hdl/bis_front.sv
`include "binomial_3x3_image_smoother_top_defines.svh"

module bis_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bis_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    input  bis_pkg::t_in_word                   i_in_word,
    input  logic                                i_space,
    output logic                                o_in_ready,
    output bis_pkg::t_push                      o_push
);
    import bis_pkg::*;

    logic [CFG_W-1:0]      r_frame_width, r_frame_height;
    logic [PIXEL_BITS-1:0] r_left, n_left, r_center, n_center;
    logic [IDX_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic                  r_draining, n_draining;

    logic [CFG_W-1:0]      w_eff, h_eff, w_last, h_last;
    logic [IDX_W-1:0]      c;
    logic [ROW_W-1:0]      y;
    logic                  c_last, y_last, accept, is_pix;
    logic                  drain_op, pix_ignored;
    logic [SUM_W-1:0]      hs0, hs1;
    t_op_kind              body_kind;
    t_op                   op0, op1, op_d;
    logic                  op0_v, op1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < CFG_W'(2)) begin
            w_eff = CFG_W'(2);
        end else if (r_frame_width > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < CFG_W'(2)) begin
            h_eff = CFG_W'(2);
        end else if (r_frame_height > CFG_W'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_frame_height;
        end
        w_last = w_eff - CFG_W'(1);
        h_last = h_eff - CFG_W'(1);
    end

    always_comb begin
        c = (CFG_W'(r_col) > w_last) ? w_last[IDX_W-1:0] : r_col;
        y = (CFG_W'(r_row) > h_last) ? h_last[ROW_W-1:0] : r_row;
        c_last = (CFG_W'(c) == w_last);
        y_last = (CFG_W'(y) == h_last);
        accept = i_in_valid && o_in_ready;
        is_pix = (i_in_word.kind == KIND_PIXEL);
        drain_op    = accept && !is_pix && r_draining;
        pix_ignored = accept && is_pix && r_draining;
    end

    // horizontal sums with the left and right edges replicated
    always_comb begin
        if (c == IDX_W'(1)) begin
            hs0 = SUM_W'(r_center) + (SUM_W'(r_center) << 1) + SUM_W'(i_in_word.pixel);
        end else begin
            hs0 = SUM_W'(r_left) + (SUM_W'(r_center) << 1) + SUM_W'(i_in_word.pixel);
        end
        hs1 = SUM_W'(r_center) + (SUM_W'(i_in_word.pixel) << 1) + SUM_W'(i_in_word.pixel);
        body_kind = (y == ROW_W'(0)) ? OP_FIRST : OP_BODY;

        op0.kind = body_kind;
        op0.idx  = c - IDX_W'(1);
        op0.hs   = hs0;
        op0.eor  = 1'b0;
        op0.eof  = 1'b0;

        op1.kind = body_kind;
        op1.idx  = c;
        op1.hs   = hs1;
        op1.eor  = 1'b1;
        op1.eof  = 1'b0;

        op_d.kind = OP_DRAIN;
        op_d.idx  = c;
        op_d.hs   = '0;
        op_d.eor  = c_last;
        op_d.eof  = c_last;

        op0_v = accept && is_pix && !r_draining && (c != IDX_W'(0));
        op1_v = accept && is_pix && !r_draining && c_last;
    end

    always_comb begin
        o_in_ready     = i_space;
        o_push.a_valid = 1'b0;
        o_push.a       = op0;
        o_push.b_valid = op0_v && op1_v;
        o_push.b       = op1;
        if (accept && !is_pix && r_draining) begin
            o_push.a_valid = 1'b1;
            o_push.a       = op_d;
        end else if (op0_v) begin
            o_push.a_valid = 1'b1;
        end else if (op1_v) begin
            o_push.a_valid = 1'b1;
            o_push.a       = op1;
        end
    end

    always_comb begin
        n_left     = r_left;
        n_center   = r_center;
        n_col      = r_col;
        n_row      = r_row;
        n_draining = r_draining;
        if (accept && !is_pix && r_draining) begin
            if (c_last) begin
                n_draining = 1'b0;
                n_col      = '0;
                n_row      = '0;
            end else begin
                n_col = c + IDX_W'(1);
            end
        end else if (accept && is_pix && !r_draining) begin
            n_left   = r_center;
            n_center = i_in_word.pixel;
            if (c_last) begin
                n_col = '0;
                if (y_last) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                end else begin
                    n_row = y + ROW_W'(1);
                end
            end else begin
                n_col = c + IDX_W'(1);
                n_row = y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_center   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_draining <= 1'b0;
        end else begin
            r_left     <= n_left;
            r_center   <= n_center;
            r_col      <= n_col;
            r_row      <= n_row;
            r_draining <= n_draining;
        end
    end

    `BIS_ASSERT_NOW(a_pair_ordered, o_push.b_valid, o_push.a_valid, "second op without first")
    `BIS_ASSERT_NOW(a_drain_single, drain_op, !o_push.b_valid, "drain tick produced two ops")
    `BIS_ASSERT_NOW(a_pix_drain_quiet, pix_ignored, !o_push.a_valid, "op from pixel in drain")

endmodule

>>> hdl/bis_queue.sv
`include "binomial_3x3_image_smoother_top_defines.svh"

module bis_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bis_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_space,
    output logic           o_head_valid,
    output bis_pkg::t_op   o_head
);
    import bis_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        o_space      = (r_count <= Q_CNT_W'(Q_DEPTH - 2));
        o_head_valid = (r_count != '0);
        o_head       = r_mem[r_rp];
        n_wp    = r_wp + Q_PTR_W'(i_push.a_valid) + Q_PTR_W'(i_push.b_valid);
        n_rp    = r_rp + Q_PTR_W'(i_pop);
        n_count = r_count + Q_CNT_W'(i_push.a_valid) + Q_CNT_W'(i_push.b_valid)
                  - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wp] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[r_wp + Q_PTR_W'(1)] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    `BIS_ASSERT_NOW(a_q_bound, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
    `BIS_ASSERT_NOW(a_q_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")
    `BIS_ASSERT_NOW(a_q_push_room, i_push.a_valid, r_count <= Q_CNT_W'(Q_DEPTH - 2), "push without room for two")

endmodule

>>> hdl/bis_back.sv
module bis_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  bis_pkg::t_op       i_head,
    output logic               o_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output bis_pkg::t_out_word o_out_word
);
    import bis_pkg::*;

    // each word holds {older row sum, newer row sum}
    logic [2*SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [2*SUM_W-1:0] r_rd;
    t_op                r_s1;
    logic               r_s1_valid, n_s1_valid;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word;

    logic [SUM_W-1:0]   older, newer;
    logic               s1_adv, we;
    logic [2*SUM_W-1:0] wdata;
    logic [OUT_W-1:0]   sum;

    always_comb begin
        older  = r_rd[2*SUM_W-1:SUM_W];
        newer  = r_rd[SUM_W-1:0];
        s1_adv = r_s1_valid && (r_s1.kind == OP_FIRST || !r_out_valid || i_out_ready);
        o_pop  = i_head_valid && (!r_s1_valid || s1_adv);
        we     = 1'b0;
        wdata  = {newer, r_s1.hs};
        sum    = OUT_W'(older) + (OUT_W'(newer) << 1) + OUT_W'(r_s1.hs);
        case (r_s1.kind)
            OP_FIRST: begin
                we    = s1_adv;
                wdata = {r_s1.hs, r_s1.hs};
            end
            OP_BODY: begin
                we = s1_adv;
            end
            OP_DRAIN: begin
                sum = OUT_W'(older) + (OUT_W'(newer) << 1) + OUT_W'(newer);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[i_head.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_s1.idx] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_head;
        end
        if (s1_adv && r_s1.kind != OP_FIRST) begin
            r_out_word.smoothed     <= sum;
            r_out_word.end_of_row   <= r_s1.eor;
            r_out_word.end_of_frame <= r_s1.eof;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv && r_s1.kind != OP_FIRST) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> sim/binomial_smoother_checker.sv
module binomial_smoother_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bis_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  bis_pkg::t_in_word             i_in_word,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  bis_pkg::t_out_word            i_out_word,
    output int                            o_pending,
    output int                            o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    logic [CFG_W-1:0]      width_reg;
    logic [CFG_W-1:0]      height_reg;
    logic [SUM_W-1:0]      row_sum_older [MAX_WIDTH];
    logic [SUM_W-1:0]      row_sum_newer [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] pix_left;
    logic [PIXEL_BITS-1:0] pix_center;
    int unsigned           col_pos;
    int unsigned           row_pos;
    bit                    draining;
    t_out_word             smoothed_due [$];

    // horizontal sum of column c enters the line stores; rows past the first blend vertically
    function automatic void blend_column(input int unsigned y, input int unsigned c,
                                         input int unsigned hs, input int unsigned wd);
        logic [SUM_W-1:0] hsum;
        int unsigned      total;
        t_out_word        word;
        hsum = SUM_W'(hs);
        if (y == 0) begin
            row_sum_older[c] = hsum;
            row_sum_newer[c] = hsum;
        end else begin
            total = row_sum_older[c] + 2 * row_sum_newer[c] + hsum;
            word.smoothed     = OUT_W'(total);
            word.end_of_row   = (c == wd - 1);
            word.end_of_frame = 1'b0;
            smoothed_due.push_back(word);
            row_sum_older[c] = row_sum_newer[c];
            row_sum_newer[c] = hsum;
        end
    endfunction

    function automatic void predict_smoothed(input t_in_word word_in);
        int unsigned wd;
        int unsigned ht;
        int unsigned c;
        int unsigned y;
        int unsigned p;
        int unsigned total;
        t_out_word   word;
        wd = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        ht = (height_reg < 2) ? 2 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        c  = (col_pos > wd - 1) ? wd - 1 : col_pos;
        if (word_in.kind == KIND_DRAIN) begin
            if (!draining) begin
                return;
            end
            // below the last row the last row's sums stand in
            total = row_sum_older[c] + 3 * row_sum_newer[c];
            word.smoothed     = OUT_W'(total);
            word.end_of_row   = (c == wd - 1);
            word.end_of_frame = word.end_of_row;
            smoothed_due.push_back(word);
            if (c == wd - 1) begin
                draining = 1'b0;
                col_pos  = 0;
                row_pos  = 0;
            end else begin
                col_pos = c + 1;
            end
        end else begin
            if (draining) begin
                return;
            end
            p = word_in.pixel;
            y = (row_pos > ht - 1) ? ht - 1 : row_pos;
            if (c == 1) begin
                blend_column(y, 0, 3 * pix_center + p, wd);
            end else if (c >= 2) begin
                blend_column(y, c - 1, pix_left + 2 * pix_center + p, wd);
            end
            if (c == wd - 1) begin
                blend_column(y, c, pix_center + 3 * p, wd);
            end
            pix_left   = pix_center;
            pix_center = word_in.pixel;
            if (c == wd - 1) begin
                col_pos = 0;
                if (y == ht - 1) begin
                    row_pos  = 0;
                    draining = 1'b1;
                end else begin
                    row_pos = y + 1;
                end
            end else begin
                col_pos = c + 1;
                row_pos = y;
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            pix_left   = '0;
            pix_center = '0;
            col_pos    = 0;
            row_pos    = 0;
            draining   = 1'b0;
            smoothed_due.delete();
            o_pending  = 0;
            o_errors   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  width_reg  = i_cfg_data;
                    REG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (smoothed_due.size() == 0) begin
                    $error("smoothed word %0d arrived with none expected",
                           i_out_word.smoothed);
                    o_errors++;
                end else begin
                    want = smoothed_due.pop_front();
                    if (i_out_word.smoothed !== want.smoothed) begin
                        $error("smoothed: expected %0d, got %0d",
                               want.smoothed, i_out_word.smoothed);
                        o_errors++;
                    end
                    if (i_out_word.end_of_row !== want.end_of_row) begin
                        $error("end_of_row: expected %0b, got %0b",
                               want.end_of_row, i_out_word.end_of_row);
                        o_errors++;
                    end
                    if (i_out_word.end_of_frame !== want.end_of_frame) begin
                        $error("end_of_frame: expected %0b, got %0b",
                               want.end_of_frame, i_out_word.end_of_frame);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_smoothed(i_in_word);
            end
            o_pending = smoothed_due.size();
        end
    end

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int          HOLD_OFF     = 4;
    localparam int          STALL_LIMIT  = 1000;
    localparam int unsigned RANDOM_WORDS = 900;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_word             in_word   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;

    int                   pending;
    int                   errors;
    int                   idle_cycles = 0;
    bit                   calm = 1'b0;
    int unsigned          eff_w;
    int unsigned          eff_h;
    int unsigned          col;
    int unsigned          row;
    int unsigned          words_sent;

    binomial_3x3_image_smoother_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    binomial_smoother_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [PIXEL_BITS-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic is_drain, input logic [PIXEL_BITS-1:0] pix);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_word.kind  <= is_drain;
        in_word.pixel <= pix;
        do @(posedge clk); while (in_ready !== 1'b1);
    endtask

    // hold input back until every expected word is out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] w_reg,
                                    input logic [CFG_W-1:0] h_reg);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FRAME_WIDTH;
        cfg_data <= w_reg;
        @(posedge clk);
        cfg_idx  <= REG_FRAME_HEIGHT;
        cfg_data <= h_reg;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_w = (w_reg < 2) ? 2 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
        eff_h = (h_reg < 2) ? 2 : (h_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_reg;
        // position past a shrunk size saturates
        if (col > eff_w - 1) begin
            col = eff_w - 1;
        end
        if (row > eff_h - 1) begin
            row = eff_h - 1;
        end
    endtask

    // part of a frame that stops short of its last pixel
    task automatic feed_partial(input int unsigned count);
        repeat (count) begin
            send_word(KIND_PIXEL, rand_pixel());
            words_sent++;
            if (col == eff_w - 1) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
        end
    endtask

    // rest of the current frame, then the drain, with optional stray words; reshape resizes the frame partway
    task automatic feed_frame(input bit reshape, input bit all_max,
                              input int unsigned noise_odds);
        int unsigned cut;
        int unsigned sent;
        bit          done;
        cut  = $urandom_range(0, eff_w * eff_h - 1);
        sent = 0;
        done = 1'b0;
        if ($urandom_range(0, noise_odds) == 0) begin
            send_word(KIND_DRAIN, rand_pixel());
        end
        while (!done) begin
            if (reshape && sent == cut) begin
                write_frame_size(CFG_W'($urandom_range(2, eff_w)),
                                 CFG_W'($urandom_range(2, 6)));
            end
            send_word(KIND_PIXEL, all_max ? {PIXEL_BITS{1'b1}} : rand_pixel());
            sent++;
            words_sent++;
            if (col == eff_w - 1) begin
                col = 0;
                if (row == eff_h - 1) begin
                    done = 1'b1;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        end
        row = 0;
        if ($urandom_range(0, noise_odds) == 0) begin
            send_word(KIND_PIXEL, rand_pixel());
        end
        repeat (eff_w) begin
            send_word(KIND_DRAIN, rand_pixel());
            words_sent++;
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial begin : stimulus
        logic [PIXEL_BITS-1:0] corner_pix [6];
        logic [CFG_W-1:0]      w_reg;
        logic [CFG_W-1:0]      h_reg;
        corner_pix = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h5555};
        eff_w      = WIDTH_RESET;
        eff_h      = HEIGHT_RESET;
        col        = 0;
        row        = 0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // start at the reset frame size, then shrink under a partly sent row
        send_word(KIND_DRAIN, 16'h1234);
        foreach (corner_pix[i]) begin
            send_word(KIND_PIXEL, corner_pix[i]);
            col++;
        end
        write_frame_size(11'd3, 11'd2);
        feed_frame(1'b0, 1'b0, 0);
        write_frame_size(11'd0, 11'd1);
        feed_frame(1'b0, 1'b1, 0);

        // widest and tallest frames, each cut short by a smaller size
        calm = 1'b1;
        write_frame_size(11'd2047, 11'd0);
        feed_partial(40);
        write_frame_size(11'd5, 11'd2);
        feed_frame(1'b0, 1'b0, 4);
        calm = 1'b0;
        write_frame_size(11'd2, 11'd1025);
        feed_partial(30);
        write_frame_size(11'd2, 11'd2);
        feed_frame(1'b0, 1'b0, 4);

        while (words_sent < RANDOM_WORDS) begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0:       w_reg = CFG_W'($urandom_range(0, 1));
                1:       w_reg = CFG_W'($urandom_range(9, 40));
                default: w_reg = CFG_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       h_reg = CFG_W'($urandom_range(0, 1));
                1:       h_reg = CFG_W'($urandom_range(7, 12));
                default: h_reg = CFG_W'($urandom_range(2, 5));
            endcase
            write_frame_size(w_reg, h_reg);
            feed_frame($urandom_range(0, 4) == 0, 1'b0, 4);
        end
        calm = 1'b0;
        settle();
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
